FILE: hw/rtl/keyed_weight_accumulator_table_macros.svh
// Assertion macros for the checker file of the accumulator table.
// No dependencies; included by bare file name.
`ifndef KEYED_WEIGHT_ACCUMULATOR_TABLE_MACROS_SVH
`define KEYED_WEIGHT_ACCUMULATOR_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KWAT_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kwat assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KWAT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kwat assertion failed");

`endif

FILE: hw/rtl/kwat_pkg.sv
// Package for the keyed weight accumulator table: sizes, opcodes, status codes,
// entry type. No dependencies.
package kwat_pkg;

    localparam int ENTRIES     = 16;
    localparam int KEY_BITS    = 8;
    localparam int WEIGHT_BITS = 32;

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_TAKE  = 3'd1;
    localparam logic [2:0] OP_ERASE = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WRITE = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_UNKNOWN    = 2'd1;
    localparam logic [1:0] ST_TOO_LITTLE = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    typedef logic [KEY_BITS-1:0]    key_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [IDX_BITS-1:0]    idx_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;

    typedef struct packed {
        key_t    key;
        weight_t weight;
    } entry_t;

endpackage

FILE: hw/rtl/keyed_weight_accumulator_table.sv
// Top level of the keyed weight accumulator table.
// Depends on kwat_pkg.
//
// A table of up to ENTRIES unique keys, each with an unsigned 16.16 weight.
// Each request transfer (opcode, key, amount) yields exactly one result
// transfer (status, weight_now). Keys and weights live in a synchronous entry
// memory with one write port and one registered read port; the valid bits sit in
// flip-flops and are cleared by reset, so no clearing pass is needed.
// Each request passes through an accept step in the idle state, a scan that
// streams every slot through the memory read port and compares its key (a
// last scan step checks the final read data), and an update step that
// writes the entry back and loads the result register. The scan through the
// one read port takes most of the time of a request.
// in_stall is low only in the idle state. The result register lets the
// next request enter while a result still waits; the update cycle waits
// only if the previous result has not been taken by then.
// Add saturates at all ones; creating an entry in a full table reports
// table full and changes nothing. New entries take the lowest free slot.
module keyed_weight_accumulator_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  key,
    input  logic [31:0] amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] weight_now
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    // Control state
    logic [1:0]                     state_reg, state_next;
    logic [kwat_pkg::ENTRIES-1:0]   valid_reg, valid_next;
    kwat_pkg::cnt_t                 cnt_reg, cnt_next;
    logic                           pend_reg, pend_next;
    logic                           found_reg, found_next;
    logic                           free_found_reg, free_found_next;
    logic                           out_valid_reg, out_valid_next;

    // Payload state
    kwat_pkg::idx_t                 pend_idx_reg, pend_idx_next;
    kwat_pkg::idx_t                 slot_reg, slot_next;
    kwat_pkg::idx_t                 free_idx_reg, free_idx_next;
    kwat_pkg::weight_t              held_reg, held_next;
    logic [2:0]                     op_reg, op_next;
    kwat_pkg::key_t                 key_reg, key_next;
    kwat_pkg::weight_t              amt_reg, amt_next;
    logic [1:0]                     status_reg, status_next;
    kwat_pkg::weight_t              wnow_reg, wnow_next;

    // Entry memory
    kwat_pkg::entry_t               mem [kwat_pkg::ENTRIES];
    kwat_pkg::entry_t               rd_data_reg;
    kwat_pkg::idx_t                 rd_addr;
    logic                           wr_en;
    kwat_pkg::idx_t                 wr_addr;
    kwat_pkg::entry_t               wr_data;

    // Update arithmetic
    logic [kwat_pkg::WEIGHT_BITS:0] sum;
    kwat_pkg::weight_t              sat_sum;
    logic                           short_held;
    kwat_pkg::weight_t              diff;
    logic                           out_free;
    logic                           hit;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign weight_now = 32'(wnow_reg);

    assign rd_addr    = cnt_reg[kwat_pkg::IDX_BITS-1:0];
    assign out_free   = !out_valid_reg || !out_stall;

    assign sum        = {1'b0, held_reg} + {1'b0, amt_reg};
    assign sat_sum    = sum[kwat_pkg::WEIGHT_BITS] ? '1 : sum[kwat_pkg::WEIGHT_BITS-1:0];
    assign short_held = (held_reg < amt_reg);
    assign diff       = held_reg - amt_reg;

    // Key match on the slot whose read data arrived this cycle
    assign hit = pend_reg && valid_reg[pend_idx_reg] && (rd_data_reg.key == key_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pend_idx_next   = pend_idx_reg;
        slot_next       = slot_reg;
        free_idx_next   = free_idx_reg;
        held_next       = held_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        amt_next        = amt_reg;
        status_next     = status_reg;
        wnow_next       = wnow_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = '{key: key_reg, weight: amt_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    key_next        = kwat_pkg::KEY_BITS'(key);
                    amt_next        = kwat_pkg::WEIGHT_BITS'(amount);
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue the next slot read while checking the previous one
                if (cnt_reg < kwat_pkg::CNT_BITS'(kwat_pkg::ENTRIES))
                begin
                    cnt_next      = cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (pend_reg)
                    begin
                        state_next = S_EXEC;
                    end
                end
                if (hit && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = pend_idx_reg;
                    held_next  = rd_data_reg.weight;
                end
                if (pend_reg && !valid_reg[pend_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pend_idx_reg;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    status_next    = kwat_pkg::ST_OK;
                    wnow_next      = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    unique case (op_reg)
                        kwat_pkg::OP_ADD, kwat_pkg::OP_WRITE:
                        begin
                            if (found_reg)
                            begin
                                wr_en          = 1'b1;
                                wr_data.weight = (op_reg == kwat_pkg::OP_ADD) ? sat_sum : amt_reg;
                                wnow_next      = wr_data.weight;
                            end
                            else if (free_found_reg)
                            begin
                                wr_en                    = 1'b1;
                                wr_addr                  = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                wnow_next                = amt_reg;
                            end
                            else
                            begin
                                status_next = kwat_pkg::ST_FULL;
                            end
                        end
                        kwat_pkg::OP_TAKE:
                        begin
                            if (!found_reg)
                            begin
                                status_next = kwat_pkg::ST_UNKNOWN;
                            end
                            else if (short_held)
                            begin
                                status_next = kwat_pkg::ST_TOO_LITTLE;
                                wnow_next   = held_reg;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_data.weight = diff;
                                wnow_next      = diff;
                            end
                        end
                        kwat_pkg::OP_ERASE:
                        begin
                            if (!found_reg)
                            begin
                                status_next = kwat_pkg::ST_UNKNOWN;
                            end
                            else
                            begin
                                valid_next[slot_reg] = 1'b0;
                            end
                        end
                        kwat_pkg::OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        kwat_pkg::OP_READ:
                        begin
                            if (!found_reg)
                            begin
                                status_next = kwat_pkg::ST_UNKNOWN;
                            end
                            else
                            begin
                                wnow_next = held_reg;
                            end
                        end
                        default:
                        begin
                            // unused opcodes: no change, ok, zero weight
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        free_idx_reg <= free_idx_next;
        held_reg     <= held_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        amt_reg      <= amt_next;
        status_reg   <= status_next;
        wnow_reg     <= wnow_next;
    end

endmodule

FILE: hw/rtl/kwat_checker.sv
// Port-level checker for keyed_weight_accumulator_table, with its bind.
// Depends on kwat_pkg and keyed_weight_accumulator_table_macros.svh.
`include "keyed_weight_accumulator_table_macros.svh"

module kwat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  opcode,
    input logic [7:0]  key,
    input logic [31:0] amount,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] weight_now
);

    // stalled result holds
    `KWAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(weight_now))
    // block is busy right after taking a request
    `KWAT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // no entry means zero weight
    `KWAT_ASSERT_IMPLY(a_zero_no_entry, clk, rst_n, out_valid && (status == kwat_pkg::ST_UNKNOWN || status == kwat_pkg::ST_FULL), weight_now == 32'd0)
    // a new result appears only as the block goes idle
    `KWAT_ASSERT_IMPLY(a_result_at_idle, clk, rst_n, $rose(out_valid), !in_stall)

endmodule

bind keyed_weight_accumulator_table kwat_checker u_kwat_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .key        (key),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .weight_now (weight_now)
);

FILE: bench/keyed_weight_accumulator_table_tb.sv
// Self-checking bench for the keyed weight accumulator table: a directed table of
// requests, then random request traffic, each result checked against a table model.
// Depends on kwat_pkg and keyed_weight_accumulator_table.
module keyed_weight_accumulator_table_tb;

    // Opcodes 6 and 7 have no meaning: the block answers ok/zero and leaves the table alone.
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int HALF_PERIOD    = 10;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int SCAN_CYCLES    = kwat_pkg::ENTRIES + 3;   // one request, accept to result
    localparam int WATCHDOG_LIMIT = 2000;                    // quiet cycles before giving up
    localparam int DIRECTED_ROWS  = 14;

    // One line of the directed table. Rows with count > 1 step the key upward.
    // Rows with fixed set carry a hand-written result; the rest use the model.
    typedef struct packed {
        logic [2:0]     op;
        kwat_pkg::key_t k;
        logic [31:0]    amt;
        logic [4:0]     count;
        logic           fixed;
        logic [1:0]     st;
        logic [31:0]    w;
    } stim_row_t;

    // A result owed by the block, in request order.
    typedef struct packed {
        logic [15:0] seq;
        logic [1:0]  status;
        logic [31:0] weight;
    } reply_t;

    // Receive-side behavior, chosen anew at random whenever the current mode runs out.
    typedef enum int {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY,
        DRAIN_PERIODIC
    } drain_mode_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    logic [2:0]     opcode;
    kwat_pkg::key_t key;
    logic [31:0]    amount;
    logic           out_valid;
    logic           out_stall;
    logic [1:0]     status;
    logic [31:0]    weight_now;

    // Table model: what the block should hold after every accepted request.
    logic              tbl_valid  [kwat_pkg::ENTRIES];
    kwat_pkg::key_t    tbl_key    [kwat_pkg::ENTRIES];
    kwat_pkg::weight_t tbl_weight [kwat_pkg::ENTRIES];

    reply_t    replies_due[$];
    stim_row_t directed_rows [DIRECTED_ROWS];

    int faults       = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int burst_left   = 0;

    keyed_weight_accumulator_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .key        (key),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .weight_now (weight_now)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Slot holding key k among valid entries, ENTRIES when absent.
    function automatic int slot_of(input kwat_pkg::key_t k);
        int i;
        for (i = 0; i < kwat_pkg::ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return kwat_pkg::ENTRIES;
    endfunction

    // Applies one request to the table model and gives the result it must produce.
    function automatic void update_table(input logic [2:0] op, input kwat_pkg::key_t k,
                                         input kwat_pkg::weight_t amt,
                                         output logic [1:0] st,
                                         output kwat_pkg::weight_t w);
        int hit;
        int spot;
        int i;
        logic [kwat_pkg::WEIGHT_BITS:0] sum;
        hit = slot_of(k);
        st  = kwat_pkg::ST_OK;
        w   = '0;
        case (op)
            kwat_pkg::OP_ADD, kwat_pkg::OP_WRITE:
            begin
                if (hit == kwat_pkg::ENTRIES)
                begin
                    // new key goes to the lowest free slot, if any
                    spot = kwat_pkg::ENTRIES;
                    for (i = kwat_pkg::ENTRIES - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            spot = i;
                    if (spot == kwat_pkg::ENTRIES)
                        st = kwat_pkg::ST_FULL;
                    else
                    begin
                        tbl_valid[spot]  = 1'b1;
                        tbl_key[spot]    = k;
                        tbl_weight[spot] = amt;
                        w = amt;
                    end
                end
                else
                begin
                    if (op == kwat_pkg::OP_ADD)
                    begin
                        // add clips at all ones
                        sum = {1'b0, tbl_weight[hit]} + {1'b0, amt};
                        tbl_weight[hit] = sum[kwat_pkg::WEIGHT_BITS] ? '1 :
                                          sum[kwat_pkg::WEIGHT_BITS-1:0];
                    end
                    else
                        tbl_weight[hit] = amt;
                    w = tbl_weight[hit];
                end
            end
            kwat_pkg::OP_TAKE:
            begin
                if (hit == kwat_pkg::ENTRIES)
                    st = kwat_pkg::ST_UNKNOWN;
                else if (tbl_weight[hit] < amt)
                begin
                    st = kwat_pkg::ST_TOO_LITTLE;
                    w  = tbl_weight[hit];
                end
                else
                begin
                    tbl_weight[hit] = tbl_weight[hit] - amt;
                    w = tbl_weight[hit];
                end
            end
            kwat_pkg::OP_ERASE:
            begin
                if (hit == kwat_pkg::ENTRIES)
                    st = kwat_pkg::ST_UNKNOWN;
                else
                    tbl_valid[hit] = 1'b0;
            end
            kwat_pkg::OP_CLEAR:
            begin
                for (i = 0; i < kwat_pkg::ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
            end
            kwat_pkg::OP_READ:
            begin
                if (hit == kwat_pkg::ENTRIES)
                    st = kwat_pkg::ST_UNKNOWN;
                else
                    w = tbl_weight[hit];
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%s", msg);
    endtask

    // Offers one request. Entered and left at a falling edge. Bursts of transfers are
    // separated by idle gaps of random length, sometimes none, so gaps land on every scan phase.
    task automatic offer(input logic [2:0] op, input kwat_pkg::key_t k,
                         input logic [31:0] amt,
                         input logic fixed, input logic [1:0] fixed_st,
                         input logic [31:0] fixed_w);
        int gap;
        reply_t due;
        logic [1:0] st;
        kwat_pkg::weight_t w;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        amount   <= amt;
        // transfer happens at the first rising edge with stall low
        do
            @(posedge clk);
        while (in_stall);
        update_table(op, k, amt, st, w);
        due.seq    = items_sent[15:0];
        due.status = fixed ? fixed_st : st;
        due.weight = fixed ? fixed_w : w;
        replies_due = {replies_due, due};
        items_sent++;
        @(negedge clk);
    endtask

    // Result side: every transfer is matched against the oldest owed result.
    always @(posedge clk)
    begin : result_check
        reply_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (replies_due.size() == 0)
                log_fault($sformatf("unrequested result: status %0d weight %h",
                                    status, weight_now));
            else
            begin
                due = replies_due.pop_front();
                if (status !== due.status || weight_now !== due.weight)
                    log_fault($sformatf("request %0d: got status %0d weight %h, want %0d %h",
                                        due.seq, status, weight_now, due.status, due.weight));
            end
        end
    end

    // Receiver: its own stall pattern, plus long hold-offs that back the
    // block up until it stalls its request side.
    initial
    begin : receiver
        drain_mode_t mode;
        int mode_left;
        int hold_left;
        int next_hold_at;
        int phase;
        out_stall    = 1'b0;
        mode         = DRAIN_FREE;
        mode_left    = 0;
        hold_left    = 0;
        next_hold_at = 250;
        phase        = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && results_seen >= next_hold_at)
            begin
                hold_left    = 150;
                next_hold_at = next_hold_at + 700;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = drain_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    DRAIN_FREE:     out_stall <= 1'b0;
                    DRAIN_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    DRAIN_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    default:        out_stall <= (phase % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("keyed_weight_accumulator_table: mismatch");
        $finish;
    end

    initial
    begin : sender
        int r;
        int j;
        int n;
        int hit;
        int roll;
        int pool_base;
        int pool_span;
        logic [2:0] op;
        kwat_pkg::key_t k;
        kwat_pkg::weight_t amt;
        kwat_pkg::weight_t held;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        opcode   = kwat_pkg::OP_ADD;
        key      = '0;
        amount   = '0;
        for (r = 0; r < kwat_pkg::ENTRIES; r++)
        begin
            tbl_valid[r]  = 1'b0;
            tbl_key[r]    = '0;
            tbl_weight[r] = '0;
        end

        // Directed part: empty-table answers, saturation, exact and short takes, write,
        // read and erase, unused opcode, then a full table refusing new keys, then clear.
        directed_rows = '{
            '{kwat_pkg::OP_READ,  8'h00, 32'h0000_0000, 5'd1,
              1'b1, kwat_pkg::ST_UNKNOWN,    32'h0000_0000},
            '{kwat_pkg::OP_TAKE,  8'h00, 32'h0000_0001, 5'd1,
              1'b1, kwat_pkg::ST_UNKNOWN,    32'h0000_0000},
            '{kwat_pkg::OP_ADD,   8'hFF, 32'hFFFF_FFFF, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'hFFFF_FFFF},
            '{kwat_pkg::OP_ADD,   8'hFF, 32'h0000_0001, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'hFFFF_FFFF},
            '{kwat_pkg::OP_TAKE,  8'hFF, 32'hFFFF_FFFF, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'h0000_0000},
            '{kwat_pkg::OP_TAKE,  8'hFF, 32'h0001_0000, 5'd1,
              1'b1, kwat_pkg::ST_TOO_LITTLE, 32'h0000_0000},
            '{kwat_pkg::OP_WRITE, 8'hFF, 32'h0001_8000, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'h0001_8000},
            '{kwat_pkg::OP_READ,  8'hFF, 32'h0000_0000, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'h0001_8000},
            '{kwat_pkg::OP_ERASE, 8'hFF, 32'h0000_0000, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'h0000_0000},
            '{OP_UNUSED_LO,       8'h55, 32'hAAAA_AAAA, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'h0000_0000},
            '{kwat_pkg::OP_WRITE, 8'h00, 32'h0000_8000, 5'd16,
              1'b0, kwat_pkg::ST_OK,         32'h0000_0000},
            '{kwat_pkg::OP_ADD,   8'h80, 32'hFFFF_FFFF, 5'd1,
              1'b1, kwat_pkg::ST_FULL,       32'h0000_0000},
            '{kwat_pkg::OP_WRITE, 8'h80, 32'h0000_0000, 5'd1,
              1'b1, kwat_pkg::ST_FULL,       32'h0000_0000},
            '{kwat_pkg::OP_CLEAR, 8'h00, 32'h0000_0000, 5'd1,
              1'b1, kwat_pkg::ST_OK,         32'h0000_0000}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
            for (j = 0; j < directed_rows[r].count; j++)
                offer(directed_rows[r].op, kwat_pkg::key_t'(directed_rows[r].k + j),
                      directed_rows[r].amt, directed_rows[r].fixed,
                      directed_rows[r].st, directed_rows[r].w);

        // Random part. Keys mostly come from a small moving pool so that hits,
        // takes against held weight and a full table are common; a tenth are
        // drawn from the whole key space. Unused opcodes do not count.
        n         = 0;
        pool_base = 0;
        pool_span = 8;
        while (n < RANDOM_ITEMS)
        begin
            if (n % 150 == 0)
            begin
                pool_base = $urandom_range(0, 255);
                pool_span = $urandom_range(3, 24);
            end
            roll = $urandom_range(0, 99);
            if (roll < 30)
                op = kwat_pkg::OP_ADD;
            else if (roll < 50)
                op = kwat_pkg::OP_TAKE;
            else if (roll < 63)
                op = kwat_pkg::OP_READ;
            else if (roll < 79)
                op = kwat_pkg::OP_WRITE;
            else if (roll < 96)
                op = kwat_pkg::OP_ERASE;
            else if (roll < 97)
                op = kwat_pkg::OP_CLEAR;
            else
                op = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;

            if ($urandom_range(0, 9) == 0)
                k = kwat_pkg::key_t'($urandom_range(0, 255));
            else
                k = kwat_pkg::key_t'(pool_base + $urandom_range(0, pool_span - 1));

            hit  = slot_of(k);
            held = (hit < kwat_pkg::ENTRIES) ? tbl_weight[hit] : '0;
            case ($urandom_range(0, 5))
                0:       amt = $urandom_range(0, 1) ? '1 : '0;
                1:       amt = $urandom;
                2:       amt = $urandom_range(0, 32'h0004_0000);
                default:
                begin
                    if (op == kwat_pkg::OP_TAKE && hit < kwat_pkg::ENTRIES)
                    begin
                        // exact, one over, or anything up to what is held
                        case ($urandom_range(0, 2))
                            0:       amt = held;
                            1:       amt = (held == '1) ? held : held + 1'b1;
                            default: amt = $urandom_range(0, held);
                        endcase
                    end
                    else if (op == kwat_pkg::OP_ADD && hit < kwat_pkg::ENTRIES)
                        // at or past the top
                        amt = ~held + kwat_pkg::weight_t'($urandom_range(0, 2));
                    else
                        amt = $urandom;
                end
            endcase

            offer(op, k, amt, 1'b0, kwat_pkg::ST_OK, '0);
            if (op != OP_UNUSED_LO && op != OP_UNUSED_HI)
                n++;
        end
        in_valid <= 1'b0;

        // Drain: everything owed must arrive, then a further quiet wait
        // catches stray extra results.
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (3 * SCAN_CYCLES) @(posedge clk);

        if (faults == 0)
            $display("keyed_weight_accumulator_table: match");
        else
            $display("keyed_weight_accumulator_table: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/kwat_pkg.sv
hw/rtl/keyed_weight_accumulator_table.sv
hw/rtl/kwat_checker.sv
bench/keyed_weight_accumulator_table_tb.sv
